@@ hdl/beacon_centroid_from_count_sum_unit_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef BEACON_CENTROID_FROM_COUNT_SUM_UNIT_MACROS_SVH
`define BEACON_CENTROID_FROM_COUNT_SUM_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define BCFCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define BCFCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BCFCS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BCFCS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/bcfcs_pkg.sv @@
package bcfcs_pkg;

    localparam int THR_W      = 19;
    localparam int COUNT_W    = 19;
    localparam int SUM_W      = 26;
    localparam int REC_W      = 48;
    localparam int COLOUR_W   = 2;
    localparam int CFG_IDX_W  = 2;

    localparam int STEPS_PER_STAGE = 2;
    localparam int NUM_STAGES      = SUM_W / STEPS_PER_STAGE;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(50);
    localparam logic [SUM_W-1:0] NOT_FOUND = SUM_W'(16'h7fff);

    // Field positions inside the raw record
    localparam int COUNT_MSB = 47;
    localparam int COUNT_LSB = 29;
    localparam int SUM_MSB   = 25;

    typedef enum logic [COLOUR_W-1:0] {
        COL_RED    = 2'd0,
        COL_YELLOW = 2'd1,
        COL_BLUE   = 2'd2
    } t_colour;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_THR    = 2'd0,
        CFG_YELLOW_THR = 2'd1,
        CFG_BLUE_THR   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic [REC_W-1:0]    raw_record;
    } t_in;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour_out;
        logic                detected;
        logic [SUM_W-1:0]    centroid_x;
    } t_out;

    // Divider word: dividend shifts out at the top while quotient bits shift in below
    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic                det;
        logic [COUNT_W-1:0]  dvsr;
        logic [COUNT_W-1:0]  rem;
        logic [SUM_W-1:0]    nq;
    } t_div;

    function automatic t_div div_step(input t_div s);
        t_div             r;
        logic [COUNT_W:0] sh;
        logic [COUNT_W:0] diff;
        logic             ge;
        r    = s;
        sh   = {s.rem, s.nq[SUM_W-1]};
        diff = sh - {1'b0, s.dvsr};
        ge   = (sh >= {1'b0, s.dvsr});
        r.rem = ge ? diff[COUNT_W-1:0] : sh[COUNT_W-1:0];
        r.nq  = {s.nq[SUM_W-2:0], ge};
        return r;
    endfunction

endpackage

@@ hdl/bcfcs_front.sv @@
module bcfcs_front
    import bcfcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_in                  i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [THR_W-1:0]     i_cfg_wdata,
    output logic                 o_vld,
    output t_div                 o_stage
);

    logic [THR_W-1:0]   r_thr_red;
    logic [THR_W-1:0]   r_thr_yellow;
    logic [THR_W-1:0]   r_thr_blue;
    logic               r_vld;
    t_div               r_stage;
    t_div               n_stage;
    logic [THR_W-1:0]   w_thr;
    logic               w_known;
    logic [COUNT_W-1:0] w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_red    <= THR_RESET;
            r_thr_yellow <= THR_RESET;
            r_thr_blue   <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RED_THR:    r_thr_red    <= i_cfg_wdata;
                CFG_YELLOW_THR: r_thr_yellow <= i_cfg_wdata;
                CFG_BLUE_THR:   r_thr_blue   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_count = i_item.raw_record[COUNT_MSB:COUNT_LSB];

    always_comb begin
        w_thr   = r_thr_red;
        w_known = 1'b1;
        unique case (t_colour'(i_item.colour))
            COL_RED:    w_thr = r_thr_red;
            COL_YELLOW: w_thr = r_thr_yellow;
            COL_BLUE:   w_thr = r_thr_blue;
            default:    w_known = 1'b0;
        endcase
        n_stage.colour = i_item.colour;
        // zero count never detects, so the divider never sees a live zero divisor
        n_stage.det    = w_known && (w_count != '0) && (w_count >= w_thr);
        n_stage.dvsr   = w_count;
        n_stage.rem    = '0;
        n_stage.nq     = i_item.raw_record[SUM_MSB:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

@@ hdl/bcfcs_div_stage.sv @@
module bcfcs_div_stage
    import bcfcs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_div i_stage,
    output logic o_vld,
    output t_div o_stage
);

    logic r_vld;
    t_div r_stage;
    t_div n_stage;

    always_comb begin
        n_stage = i_stage;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            n_stage = div_step(n_stage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

@@ hdl/beacon_centroid_from_count_sum_unit.sv @@
// Beacon centroid unit: turns a packed camera record (pixel count and x-coordinate
// sum) into a detected flag and centroid for one colour.
// Input: raise i_start with i_item for one cycle per record; the word is taken at
// that edge. o_busy is always low, so a record may be offered in every cycle.
// Output: o_done pulses for one cycle with o_result; there is no back-pressure.
// Pipeline: one unpack/threshold stage loaded at the accepting edge, 13 divider
// stages of two quotient bits each, and the result register that drives o_done.
// Throughput is one record per clock, set by the restoring divider being fully
// unrolled into stages.
// Configuration: i_cfg_we writes i_cfg_wdata into threshold i_cfg_idx
// (0 red, 1 yellow, 2 blue, 3 ignored); write only while no record is in flight.
// Reset (synchronous, i_rst_n low): thresholds return to 50 and every record in
// flight is dropped; no result appears for it.
`include "beacon_centroid_from_count_sum_unit_macros.svh"

module beacon_centroid_from_count_sum_unit
    import bcfcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_in                  i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [THR_W-1:0]     i_cfg_wdata,
    output logic                 o_done,
    output t_out                 o_result
);

    logic w_accept;
    logic w_vld [0:NUM_STAGES];
    t_div w_stg [0:NUM_STAGES];
    logic r_done;
    t_out r_result;
    t_out n_result;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    bcfcs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_vld       (w_vld[0]),
        .o_stage     (w_stg[0])
    );

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_div
        bcfcs_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_stage (w_stg[g]),
            .o_vld   (w_vld[g+1]),
            .o_stage (w_stg[g+1])
        );
    end

    always_comb begin
        n_result.colour_out = w_stg[NUM_STAGES].colour;
        n_result.detected   = w_stg[NUM_STAGES].det;
        n_result.centroid_x = w_stg[NUM_STAGES].det ? w_stg[NUM_STAGES].nq : NOT_FOUND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_vld[NUM_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `BCFCS_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, w_accept, w_vld[0])
    `BCFCS_ASSERT_NXT(a_last_to_done, i_clk, i_rst_n, w_vld[NUM_STAGES], o_done)
    `BCFCS_ASSERT_IMP(a_miss_value, i_clk, i_rst_n, o_done && !o_result.detected, o_result.centroid_x == NOT_FOUND)
    `BCFCS_ASSERT_IMP(a_det_colour, i_clk, i_rst_n, o_done && o_result.detected, o_result.colour_out != 2'd3)
    `BCFCS_ASSERT_IMP(a_det_dvsr, i_clk, i_rst_n, w_vld[0] && w_stg[0].det, w_stg[0].dvsr != '0)

endmodule
